// ----- hw/rtl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// Polar / rectangular converter package
// Item types, fixed-point constants and the arctangent table shared by the
// pipeline stages of the converter.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Width of the internal x, y and angle words.
  localparam int DW = 35;
  // Width of the rounded results ahead of clipping.
  localparam int RW = 27;

  localparam logic OP_TO_RECT  = 1'b0;
  localparam logic OP_TO_POLAR = 1'b1;

  localparam logic signed [DW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [DW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [DW-1:0] HALF_PI_Q30 = 35'sd1686629713;

  localparam logic signed [30:0] GAIN_Q30   = 31'sd652032874;
  localparam logic        [29:0] GAIN_Q30_U = 30'd652032874;

  localparam logic signed [RW-1:0] CLIP_HI = 27'sd8388607;
  localparam logic signed [RW-1:0] CLIP_LO = -27'sd8388608;
  localparam logic signed [23:0]   RES_HI  = 24'sd8388607;
  localparam logic signed [23:0]   RES_LO  = -24'sd8388608;

  typedef struct packed {
    logic               opcode;
    logic signed [23:0] operand_a;
    logic signed [23:0] operand_b;
  } prc_in_t;

  typedef struct packed {
    logic signed [23:0] result_a;
    logic signed [23:0] result_b;
    logic               saturated;
  } prc_out_t;

  // One item in flight: vectoring or rotation, a hold mark for points on the
  // x axis, and the working coordinates and angle.
  typedef struct packed {
    logic                 vec;
    logic                 hold;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } prc_slot_t;

  function automatic logic signed [DW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [DW-1:0] val;
    case (idx)
      5'd0:    val = 35'sh03243F6A8;
      5'd1:    val = 35'sh01DAC6705;
      5'd2:    val = 35'sh00FADBAFC;
      5'd3:    val = 35'sh007F56EA6;
      5'd4:    val = 35'sh003FEAB76;
      5'd5:    val = 35'sh001FFD55B;
      5'd6:    val = 35'sh000FFFAAA;
      5'd7:    val = 35'sh0007FFF55;
      5'd8:    val = 35'sh0003FFFEA;
      5'd9:    val = 35'sh0001FFFFD;
      5'd10:   val = 35'sh0000FFFFF;
      5'd11:   val = 35'sh00007FFFF;
      5'd12:   val = 35'sh00003FFFF;
      5'd13:   val = 35'sh00001FFFF;
      5'd14:   val = 35'sh00000FFFF;
      5'd15:   val = 35'sh000007FFF;
      5'd16:   val = 35'sh000003FFF;
      5'd17:   val = 35'sh000001FFF;
      5'd18:   val = 35'sh000000FFF;
      5'd19:   val = 35'sh0000007FF;
      5'd20:   val = 35'sh0000003FF;
      5'd21:   val = 35'sh0000001FF;
      5'd22:   val = 35'sh0000000FF;
      5'd23:   val = 35'sh00000007F;
      5'd24:   val = 35'sh00000003F;
      5'd25:   val = 35'sh00000001F;
      5'd26:   val = 35'sh00000000F;
      5'd27:   val = 35'sh000000008;
      5'd28:   val = 35'sh000000004;
      5'd29:   val = 35'sh000000002;
      5'd30:   val = 35'sh000000001;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/prc_pre.sv -----
// ----------------------------------------------------------------------------
// Converter front end
// Four register stages: operand decode and angle wrap, quadrant fold, gain
// multiply and rounding of the prescaled radius.
// ----------------------------------------------------------------------------
module prc_pre (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  prc_pkg::prc_in_t   in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output prc_pkg::prc_slot_t out_slot
);
  import prc_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  prc_slot_t s1, s2, s3, s4;
  prc_slot_t s1_next, s2_next, s4_next;
  logic signed [55:0] prod3;
  logic signed [24:0] r2;
  logic signed [DW-1:0] a_ext, b_ext, z_ang;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign a_ext = DW'(in_item.operand_a);
  assign b_ext = DW'(in_item.operand_b);
  assign z_ang = b_ext <<< 10;
  assign r2 = s2.x[24:0];

  always_comb begin
    s1_next = '0;
    if (in_item.opcode == OP_TO_RECT) begin
      s1_next.x = a_ext;
      if (z_ang > PI_Q30) begin
        s1_next.z = z_ang - TWO_PI_Q30;
      end else if (z_ang < -PI_Q30) begin
        s1_next.z = z_ang + TWO_PI_Q30;
      end else begin
        s1_next.z = z_ang;
      end
    end else if (in_item.operand_b == '0) begin
      // A point on the x axis skips the iterations.
      s1_next.vec  = 1'b1;
      s1_next.hold = 1'b1;
      if (in_item.operand_a < 0) begin
        s1_next.x = -(a_ext <<< 8);
        s1_next.z = PI_Q30;
      end else begin
        s1_next.x = a_ext <<< 8;
      end
    end else begin
      s1_next.vec = 1'b1;
      if (in_item.operand_a < 0) begin
        s1_next.x = -(a_ext <<< 8);
        s1_next.y = -(b_ext <<< 8);
        s1_next.z = (in_item.operand_b > 0) ? PI_Q30 : -PI_Q30;
      end else begin
        s1_next.x = a_ext <<< 8;
        s1_next.y = b_ext <<< 8;
      end
    end
  end

  always_comb begin
    s2_next = s1;
    if (!s1.vec) begin
      if (s1.z > HALF_PI_Q30) begin
        s2_next.z = s1.z - PI_Q30;
        s2_next.x = -s1.x;
      end else if (s1.z < -HALF_PI_Q30) begin
        s2_next.z = s1.z + PI_Q30;
        s2_next.x = -s1.x;
      end
    end
  end

  always_comb begin
    s4_next = s3;
    if (!s3.vec) begin
      s4_next.x = DW'((prod3 + 56'sd2097152) >>> 22);
      s4_next.y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) begin
      s3    <= s2;
      prod3 <= r2 * GAIN_Q30;
    end
    if (en4) s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_slot  = s4;

endmodule

// ----- hw/rtl/prc_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// CORDIC iteration stage
// One shift-add micro-rotation, in rotation or vectoring mode, behind a
// register with its own valid bit.
// ----------------------------------------------------------------------------
module prc_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  prc_pkg::prc_slot_t in_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output prc_pkg::prc_slot_t out_slot
);
  import prc_pkg::*;

  logic en, v;
  logic pos;
  logic signed [DW-1:0] xs, ys, ang;
  prc_slot_t slot, slot_next;

  assign en = !v || out_ready;
  assign in_ready = en;

  assign xs  = in_slot.x >>> SHIFT;
  assign ys  = in_slot.y >>> SHIFT;
  assign ang = atan_q30(5'(SHIFT));
  assign pos = in_slot.vec ? in_slot.y[DW-1] : !in_slot.z[DW-1];

  always_comb begin
    slot_next = in_slot;
    if (!in_slot.hold) begin
      if (pos) begin
        slot_next.x = in_slot.x - ys;
        slot_next.y = in_slot.y + xs;
        slot_next.z = in_slot.z - ang;
      end else begin
        slot_next.x = in_slot.x + ys;
        slot_next.y = in_slot.y - xs;
        slot_next.z = in_slot.z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) slot <= slot_next;
  end

  assign out_valid = v;
  assign out_slot  = slot;

endmodule

// ----- hw/rtl/prc_post.sv -----
// ----------------------------------------------------------------------------
// Converter back end
// Radius gain correction as two partial products, rounding to the output
// formats, and clipping into the output register.
// ----------------------------------------------------------------------------
module prc_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  prc_pkg::prc_slot_t in_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output prc_pkg::prc_out_t  out_item
);
  import prc_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic                 vec1, hold1;
  logic        [46:0]   pl1;
  logic signed [48:0]   ph1;
  logic signed [DW-1:0] x1, y1, z1;
  logic signed [17:0]   xh;

  logic                 gain2;
  logic signed [63:0]   sum2;
  logic signed [RW-1:0] ra_d2, rb2;

  logic signed [RW-1:0] ra3, rb3;

  prc_out_t item4, item_next;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign xh = in_slot.x[DW-1:17];

  always_comb begin
    item_next = '0;
    if (ra3 > CLIP_HI) begin
      item_next.result_a  = RES_HI;
      item_next.saturated = 1'b1;
    end else if (ra3 < CLIP_LO) begin
      item_next.result_a  = RES_LO;
      item_next.saturated = 1'b1;
    end else begin
      item_next.result_a = ra3[23:0];
    end
    if (rb3 > CLIP_HI) begin
      item_next.result_b  = RES_HI;
      item_next.saturated = 1'b1;
    end else if (rb3 < CLIP_LO) begin
      item_next.result_b  = RES_LO;
      item_next.saturated = 1'b1;
    end else begin
      item_next.result_b = rb3[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      vec1  <= in_slot.vec;
      hold1 <= in_slot.hold;
      x1    <= in_slot.x;
      y1    <= in_slot.y;
      z1    <= in_slot.z;
      pl1   <= in_slot.x[16:0] * GAIN_Q30_U;
      ph1   <= xh * GAIN_Q30;
    end
    if (en2) begin
      gain2 <= vec1 && !hold1;
      sum2  <= (64'(ph1) <<< 17) + $signed({17'b0, pl1});
      ra_d2 <= RW'((x1 + 35'sd128) >>> 8);
      rb2   <= vec1 ? RW'((z1 + 35'sd512) >>> 10) : RW'((y1 + 35'sd128) >>> 8);
    end
    if (en3) begin
      ra3 <= gain2 ? RW'((sum2 + 64'sd137438953472) >>> 38) : ra_d2;
      rb3 <= rb2;
    end
    if (en4) item4 <= item_next;
  end

  assign out_valid = v4;
  assign out_item  = item4;

endmodule

// ----- hw/rtl/polar_rectangular_converter.sv -----
// ----------------------------------------------------------------------------
// Polar / rectangular converter
// Converts a radius and angle to x and y, or x and y to a radius and a
// full-quadrant angle, with a fully pipelined CORDIC. One item is accepted
// per cycle while req_stall is low; each item passes through four front end
// stages, one register per CORDIC iteration (at most 32) and four back end
// stages. Every stage has its own valid bit and advances whenever the stage
// after it is empty or moving, so empty slots close up and new items keep
// entering, until the stages fill, while a finished result waits for the
// output stall to drop. Coordinates and radius are Q12.12, angles Q3.20
// radians; a result outside 24 bits is clipped and flagged.
// ----------------------------------------------------------------------------
module polar_rectangular_converter #(
  parameter int ITERATIONS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  prc_pkg::prc_in_t  req,
  output logic              res_valid,
  input  logic              res_stall,
  output prc_pkg::prc_out_t res
);
  import prc_pkg::*;

  localparam int STAGES = (ITERATIONS > 32) ? 32 : ITERATIONS;

  logic            pre_ready;
  logic            post_ready;
  logic [STAGES:0] cv;
  logic [STAGES:0] cr;
  prc_slot_t       cs [STAGES+1];

  assign req_stall  = !pre_ready;
  assign post_ready = !res_stall;

  prc_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (pre_ready),
    .in_item   (req),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_slot  (cs[0])
  );

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    prc_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_slot   (cs[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_slot  (cs[i+1])
    );
  end

  prc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[STAGES]),
    .in_ready  (cr[STAGES]),
    .in_slot   (cs[STAGES]),
    .out_valid (res_valid),
    .out_ready (post_ready),
    .out_item  (res)
  );

`ifndef NO_ASSERTIONS
  a_no_stall_through: assert property (@(posedge clk) disable iff (rst)
    !res_stall |-> !req_stall)
    else $error("Input stalled although the output is free.");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.saturated) |->
      (res.result_a == RES_HI || res.result_a == RES_LO ||
       res.result_b == RES_HI || res.result_b == RES_LO))
    else $error("Saturation flag set without a clipped result.");

  a_vector_x_positive: assert property (@(posedge clk) disable iff (rst)
    (cv[STAGES] && cs[STAGES].vec && !cs[STAGES].hold) |-> !cs[STAGES].x[DW-1])
    else $error("Vectoring item left the iterations with a negative x.");
`endif

endmodule

// ----- tb/sv/polar_rectangular_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar / rectangular converter testbench
// Sends directed corner items and then random conversions in both directions
// through the valid/stall request port while the result port stalls at random.
// A bit-exact CORDIC predictor in the scoreboard works out each expected
// result, and every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module polar_rectangular_converter_tb;

  localparam int ITERATIONS   = 20;
  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_FROM    = 470;

  typedef prc_pkg::prc_in_t  req_t;
  typedef prc_pkg::prc_out_t res_t;

  class coord_scoreboard;
    localparam int     STEPS       = (ITERATIONS > 32) ? 32 : ITERATIONS;
    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_TWO_PI  = 64'sd6746518852;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint PI_OUT      = 64'sd3294199;
    localparam longint K_GAIN      = 64'sd652032874;
    localparam longint TOP24       = 64'sd8388607;
    localparam longint BOT24       = -64'sd8388608;

    req_t   sent_items[$];
    res_t   awaited[$];
    int     errors;
    int     n_rect;
    int     n_polar;
    int     n_clipped;
    int     n_checked;

    function longint atan_step(int i);
      case (i)
        0:  return 64'h3243F6A8;
        1:  return 64'h1DAC6705;
        2:  return 64'h0FADBAFC;
        3:  return 64'h07F56EA6;
        4:  return 64'h03FEAB76;
        5:  return 64'h01FFD55B;
        6:  return 64'h00FFFAAA;
        7:  return 64'h007FFF55;
        8:  return 64'h003FFFEA;
        9:  return 64'h001FFFFD;
        10: return 64'h000FFFFF;
        11: return 64'h0007FFFF;
        12: return 64'h0003FFFF;
        13: return 64'h0001FFFF;
        14: return 64'h0000FFFF;
        15: return 64'h00007FFF;
        16: return 64'h00003FFF;
        17: return 64'h00001FFF;
        18: return 64'h00000FFF;
        19: return 64'h000007FF;
        20: return 64'h000003FF;
        21: return 64'h000001FF;
        22: return 64'h000000FF;
        23: return 64'h0000007F;
        24: return 64'h0000003F;
        25: return 64'h0000001F;
        26: return 64'h0000000F;
        27: return 64'h00000008;
        28: return 64'h00000004;
        29: return 64'h00000002;
        30: return 64'h00000001;
        default: return 64'h0;
      endcase
    endfunction

    function longint round_off(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function logic [23:0] clip24(longint v, inout bit flag);
      if (v > TOP24) begin
        v = TOP24;
        flag = 1'b1;
      end
      if (v < BOT24) begin
        v = BOT24;
        flag = 1'b1;
      end
      return v[23:0];
    endfunction

    function res_t cordic_convert(req_t item);
      longint a, b, x, y, z, nx, r, ra, rb;
      bit     clipped;
      res_t   o;
      a = $signed(item.operand_a);
      b = $signed(item.operand_b);
      clipped = 1'b0;
      if (item.opcode == prc_pkg::OP_TO_RECT) begin
        r = a;
        z = b * 1024;
        if (z > ANG_PI) z -= ANG_TWO_PI;
        else if (z < -ANG_PI) z += ANG_TWO_PI;
        if (z > ANG_HALF_PI) begin
          z -= ANG_PI;
          r = -r;
        end else if (z < -ANG_HALF_PI) begin
          z += ANG_PI;
          r = -r;
        end
        x = round_off(r * K_GAIN, 22);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
          end
          x = nx;
        end
        ra = round_off(x, 8);
        rb = round_off(y, 8);
      end else if (b == 0) begin
        ra = (a < 0) ? -a : a;
        rb = (a < 0) ? PI_OUT : 0;
      end else begin
        x = a * 256;
        y = b * 256;
        z = 0;
        if (x < 0) begin
          x = -x;
          y = -y;
          z = (b > 0) ? ANG_PI : -ANG_PI;
        end
        for (int i = 0; i < STEPS; i++) begin
          if (y < 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
          end
          x = nx;
        end
        ra = round_off(x * K_GAIN, 38);
        rb = round_off(z, 10);
      end
      o.result_a  = clip24(ra, clipped);
      o.result_b  = clip24(rb, clipped);
      o.saturated = clipped;
      return o;
    endfunction

    function void note_request(req_t item);
      res_t want;
      want = cordic_convert(item);
      sent_items.push_back(item);
      awaited.push_back(want);
      if (item.opcode == prc_pkg::OP_TO_RECT) n_rect++;
      else n_polar++;
      if (want.saturated) n_clipped++;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(res_t got);
      req_t src;
      res_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %0d %0d %0d",
                         got.result_a, got.result_b, got.saturated));
      end else begin
        src  = sent_items.pop_front();
        want = awaited.pop_front();
        n_checked++;
        if (got.result_a !== want.result_a || got.result_b !== want.result_b ||
            got.saturated !== want.saturated)
          report($sformatf("op %0d a=%0d b=%0d: got %0d %0d %0d, want %0d %0d %0d",
                           src.opcode, src.operand_a, src.operand_b,
                           got.result_a, got.result_b, got.saturated,
                           want.result_a, want.result_b, want.saturated));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;
  bit   quiet;

  coord_scoreboard ledger = new;

  polar_rectangular_converter #(.ITERATIONS(ITERATIONS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) ledger.note_request(req);
      if (res_valid && !res_stall) ledger.check_result(res);
    end
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && !rst) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(20, 60)) @(negedge clk);
        end else if ($urandom_range(0, 3) == 0) begin
          res_stall <= 1'b1;
          repeat ($urandom_range(1, 12) - 1) @(negedge clk);
          @(negedge clk);
          res_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("polar_rectangular_converter_tb NOT OK");
    $finish;
  end

  function automatic req_t make_item(logic op, int a, int b);
    req_t it;
    it.opcode    = op;
    it.operand_a = 24'(a);
    it.operand_b = 24'(b);
    return it;
  endfunction

  function automatic req_t pick_item();
    req_t it;
    int   sel;
    int   a;
    int   b;
    logic op;
    sel = $urandom_range(0, 19);
    op  = 1'($urandom_range(0, 1));
    a   = $urandom;
    b   = $urandom;
    case (sel)
      0, 1, 2: begin
        a = $urandom_range(0, 16383) - 8192;
        b = $urandom_range(0, 16383) - 8192;
      end
      3: begin
        op = prc_pkg::OP_TO_POLAR;
        b  = 0;
      end
      4: begin
        op = prc_pkg::OP_TO_POLAR;
        a  = 0;
      end
      5: begin
        op = prc_pkg::OP_TO_RECT;
        b  = ($urandom_range(0, 1) ? 1 : -1) * (3294199 + $urandom_range(0, 4) - 2);
      end
      6: begin
        op = prc_pkg::OP_TO_RECT;
        b  = ($urandom_range(0, 1) ? 1 : -1) * (1647099 + $urandom_range(0, 4) - 2);
      end
      7: begin
        a = $urandom_range(0, 1) ? 8388607 - $urandom_range(0, 3000)
                                 : -8388608 + $urandom_range(0, 3000);
      end
      default: ;
    endcase
    it = make_item(op, a, b);
    return it;
  endfunction

  task automatic send(req_t item);
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic maybe_idle();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    req_t corners[$];
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    quiet     = 1'b0;

    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 0, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 8388607, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, -8388608, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 4096, 3294199));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 4096, -3294199));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 4096, 3294200));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 4096, 1647099));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 4096, 1647100));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 4096, -1647100));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, 8388607, 8388607));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, -8388608, -8388608));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, -8388608, 3294199));
    corners.push_back(make_item(prc_pkg::OP_TO_RECT, -4096, 823550));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, 0, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, 4096, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, -4096, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, -8388608, 0));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, 8388607, 8388607));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, -8388608, -8388608));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, 0, 8388607));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, 0, -8388608));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, -8388608, 1));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, -8388608, -1));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, 1, 1));
    corners.push_back(make_item(prc_pkg::OP_TO_POLAR, -1, -1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corners[i]) begin
      send(corners[i]);
      maybe_idle();
    end
    drain();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) drain();
      if (k >= CALM_FROM) quiet = 1'b1;
      send(pick_item());
      maybe_idle();
    end
    drain();
    repeat (ITERATIONS + 16) @(posedge clk);

    $display("Checked %0d results: %0d polar to rectangular, %0d rectangular to polar,",
             ledger.n_checked, ledger.n_rect, ledger.n_polar);
    $display("%0d of them clipped, with random idling on both ports.", ledger.n_clipped);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("polar_rectangular_converter_tb OK");
    end else begin
      $display("polar_rectangular_converter_tb NOT OK");
    end
    $finish;
  end

endmodule
